// ----- src/ppe_pkg.sv -----
// ----------------------------------------------------------------------------
// ppe_pkg
// shared types, codes and helpers of the particle partition engine
// ----------------------------------------------------------------------------
package ppe_pkg;

  localparam int CAPACITY_DEF = 1024;
  localparam int IDX_W = 10;
  localparam int PTR_W = 11;
  localparam int WORD_W = 32;
  localparam int RUNG_W = 8;

  // input command codes
  localparam logic [1:0] CMD_WRITE = 2'd0;
  localparam logic [1:0] CMD_PART = 2'd1;
  localparam logic [1:0] CMD_READ = 2'd2;

  // dimension codes
  localparam logic [1:0] DIM_X = 2'd0;
  localparam logic [1:0] DIM_Y = 2'd1;
  localparam logic [1:0] DIM_Z = 2'd2;

  // classified operation codes
  localparam logic [2:0] OP_NOP = 3'd0;
  localparam logic [2:0] OP_WRITE = 3'd1;
  localparam logic [2:0] OP_READ = 3'd2;
  localparam logic [2:0] OP_PART = 3'd3;
  localparam logic [2:0] OP_SPLIT = 3'd4;

  typedef struct packed {
    logic [WORD_W-1:0] pos_x;
    logic [WORD_W-1:0] pos_y;
    logic [WORD_W-1:0] pos_z;
    logic [WORD_W-1:0] vel_x;
    logic [WORD_W-1:0] vel_y;
    logic [WORD_W-1:0] vel_z;
    logic [RUNG_W-1:0] rung;
  } record_t;

  typedef struct packed {
    logic [2:0]        op;
    logic [PTR_W-1:0]  first;
    logic [PTR_W-1:0]  last;
    logic [1:0]        dim;
    logic [WORD_W-1:0] pivot;
    record_t           rec;
  } cmd_t;

  function automatic logic [WORD_W-1:0] key_of(input record_t r, input logic [1:0] dim);
    logic [WORD_W-1:0] k;
    case (dim)
      DIM_X:   k = r.pos_x;
      DIM_Y:   k = r.pos_y;
      default: k = r.pos_z;
    endcase
    return k;
  endfunction

endpackage

// ----- src/ppe_front.sv -----
// ----------------------------------------------------------------------------
// ppe_front
// classifies incoming commands: range checks, end saturation, empty ranges
// ----------------------------------------------------------------------------
module ppe_front
  import ppe_pkg::*;
#(
  parameter int CAPACITY = CAPACITY_DEF
) (
  input  logic [1:0]        command,
  input  logic [IDX_W-1:0]  index,
  input  logic [PTR_W-1:0]  range_end,
  input  logic [1:0]        split_dim,
  input  logic [WORD_W-1:0] pivot,
  input  record_t           rec,
  output cmd_t              cmd
);

  logic             idx_ok;
  logic [PTR_W-1:0] first;
  logic [PTR_W-1:0] last;

  always_comb begin
    idx_ok = (32'(index) < 32'(CAPACITY));
    first = PTR_W'(index);
    // saturate end to capacity
    if (32'(range_end) > 32'(CAPACITY)) begin
      last = PTR_W'(CAPACITY);
    end else begin
      last = range_end;
    end

    cmd.first = first;
    cmd.last = last;
    cmd.pivot = pivot;
    cmd.rec = rec;
    cmd.dim = (split_dim == DIM_X || split_dim == DIM_Y) ? split_dim : DIM_Z;

    unique case (command)
      CMD_WRITE: cmd.op = idx_ok ? OP_WRITE : OP_NOP;
      CMD_READ:  cmd.op = idx_ok ? OP_READ : OP_NOP;
      CMD_PART:  cmd.op = (first < last) ? OP_PART : OP_SPLIT;
      default:   cmd.op = OP_NOP;
    endcase
  end

endmodule

// ----- src/ppe_cmd_fifo.sv -----
// ----------------------------------------------------------------------------
// ppe_cmd_fifo
// two-entry queue of classified commands between front and back
// ----------------------------------------------------------------------------
module ppe_cmd_fifo
  import ppe_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic wr_en,
  input  cmd_t wr_cmd,
  output logic full,
  input  logic rd_en,
  output cmd_t rd_cmd,
  output logic empty
);

  cmd_t       entry [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;

  assign full = (count == 2'd2);
  assign empty = (count == 2'd0);
  assign rd_cmd = entry[rd_ptr];

  always_ff @(posedge clk) begin
    if (wr_en && !full) begin
      entry[wr_ptr] <= wr_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count <= 2'd0;
    end else begin
      if (wr_en && !full) begin
        wr_ptr <= ~wr_ptr;
      end
      if (rd_en && !empty) begin
        rd_ptr <= ~rd_ptr;
      end
      count <= count + 2'(wr_en && !full) - 2'(rd_en && !empty);
    end
  end

endmodule

// ----- src/ppe_back.sv -----
// ----------------------------------------------------------------------------
// ppe_back
// record store and the sequencer that runs write, read and partition
// ----------------------------------------------------------------------------
module ppe_back
  import ppe_pkg::*;
#(
  parameter int CAPACITY = CAPACITY_DEF
) (
  input  logic             clk,
  input  logic             rst,
  input  cmd_t             cmd,
  input  logic             cmd_empty,
  output logic             cmd_pop,
  input  logic             pop,
  output logic             empty,
  output logic [PTR_W-1:0] split_point,
  output record_t          out_rec
);

  localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_READ = 3'd1;
  localparam logic [2:0] S_LO_RD = 3'd2;
  localparam logic [2:0] S_LO_CHK = 3'd3;
  localparam logic [2:0] S_HI_CHK = 3'd4;
  localparam logic [2:0] S_SWAP = 3'd5;
  localparam logic [2:0] S_EMIT = 3'd6;

  record_t mem [CAPACITY];
  record_t rdata;

  logic [2:0]        state, state_next;
  logic [PTR_W-1:0]  lo, lo_next;
  logic [PTR_W-1:0]  hi, hi_next;
  logic [1:0]        dim, dim_next;
  logic [WORD_W-1:0] pivot, pivot_next;
  record_t           rec_lo, rec_lo_next;
  record_t           rec_hi, rec_hi_next;
  logic [PTR_W-1:0]  res_split, res_split_next;
  record_t           res_rec, res_rec_next;
  logic              out_valid;

  logic              wr_en;
  logic [PTR_W-1:0]  wr_addr;
  record_t           wr_data;
  logic [PTR_W-1:0]  rd_addr;
  logic [PTR_W-1:0]  lo_inc;
  logic [WORD_W-1:0] key;
  logic              load_out;

  assign empty = !out_valid;
  assign lo_inc = lo + PTR_W'(1);
  assign key = key_of(rdata, dim);
  assign load_out = (state == S_EMIT) && (!out_valid || pop);
  assign cmd_pop = (state == S_IDLE) && !cmd_empty;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[AW'(wr_addr)] <= wr_data;
    end
    rdata <= mem[AW'(rd_addr)];
  end

  always_comb begin
    state_next = state;
    lo_next = lo;
    hi_next = hi;
    dim_next = dim;
    pivot_next = pivot;
    rec_lo_next = rec_lo;
    rec_hi_next = rec_hi;
    res_split_next = res_split;
    res_rec_next = res_rec;
    wr_en = 1'b0;
    wr_addr = lo;
    wr_data = rec_hi;
    rd_addr = lo;

    unique case (state)
      S_IDLE: begin
        if (!cmd_empty) begin
          lo_next = cmd.first;
          hi_next = cmd.last;
          dim_next = cmd.dim;
          pivot_next = cmd.pivot;
          res_split_next = '0;
          res_rec_next = '0;
          rd_addr = cmd.first;
          unique case (cmd.op)
            OP_WRITE: begin
              wr_en = 1'b1;
              wr_addr = cmd.first;
              wr_data = cmd.rec;
              state_next = S_EMIT;
            end
            OP_READ:  state_next = S_READ;
            OP_PART:  state_next = S_LO_RD;
            OP_SPLIT: begin
              res_split_next = cmd.last;
              state_next = S_EMIT;
            end
            default:  state_next = S_EMIT;
          endcase
        end
      end
      S_READ: begin
        res_rec_next = rdata;
        state_next = S_EMIT;
      end
      S_LO_RD: begin
        rd_addr = lo;
        state_next = S_LO_CHK;
      end
      S_LO_CHK: begin
        rec_lo_next = rdata;
        if (key >= pivot) begin
          // scan down from the high end
          hi_next = hi - PTR_W'(1);
          rd_addr = hi - PTR_W'(1);
          state_next = S_HI_CHK;
        end else begin
          lo_next = lo_inc;
          if (lo_inc < hi) begin
            state_next = S_LO_RD;
          end else begin
            res_split_next = hi;
            state_next = S_EMIT;
          end
        end
      end
      S_HI_CHK: begin
        if (key < pivot) begin
          wr_en = 1'b1;
          wr_addr = hi;
          wr_data = rec_lo;
          rec_hi_next = rdata;
          state_next = S_SWAP;
        end else if (lo == hi) begin
          lo_next = lo_inc;
          res_split_next = hi;
          state_next = S_EMIT;
        end else begin
          hi_next = hi - PTR_W'(1);
          rd_addr = hi - PTR_W'(1);
        end
      end
      S_SWAP: begin
        wr_en = 1'b1;
        wr_addr = lo;
        wr_data = rec_hi;
        lo_next = lo_inc;
        if (lo_inc < hi) begin
          state_next = S_LO_RD;
        end else begin
          res_split_next = hi;
          state_next = S_EMIT;
        end
      end
      S_EMIT: begin
        if (load_out) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    lo <= lo_next;
    hi <= hi_next;
    dim <= dim_next;
    pivot <= pivot_next;
    rec_lo <= rec_lo_next;
    rec_hi <= rec_hi_next;
    res_split <= res_split_next;
    res_rec <= res_rec_next;
    if (load_out) begin
      split_point <= res_split;
      out_rec <= res_rec;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (load_out) begin
        out_valid <= 1'b1;
      end else if (pop) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

// ----- src/particle_partition_engine_top.sv -----
// ----------------------------------------------------------------------------
// particle_partition_engine_top
// particle record store with in-place two-ended partition
// ----------------------------------------------------------------------------
// Holds CAPACITY particle records in one single-port-write, registered-read
// memory. A write goes to memory as its command leaves the command queue; a
// read goes through the registered read. A partition scans from the low end,
// reading a slot and then checking its key, scans down from the high end one
// slot per check, and writes each swapped pair of records in two steps; the
// single memory read port and the one record written per cycle set its pace.
// A two-entry command queue lets new commands come in while the engine works
// and while a result waits on the output register. There is no clearing pass:
// slots hold whatever was last written.
module particle_partition_engine_top
  import ppe_pkg::*;
#(
  parameter int CAPACITY = CAPACITY_DEF
) (
  input  logic                clk,
  input  logic                rst,
  // command side
  input  logic                push,
  output logic                full,
  input  logic [1:0]          command,
  input  logic [IDX_W-1:0]    index,
  input  logic [PTR_W-1:0]    range_end,
  input  logic [1:0]          split_dim,
  input  logic [WORD_W-1:0]   pivot,
  input  logic [WORD_W-1:0]   pos_x,
  input  logic [WORD_W-1:0]   pos_y,
  input  logic [WORD_W-1:0]   pos_z,
  input  logic [WORD_W-1:0]   vel_x,
  input  logic [WORD_W-1:0]   vel_y,
  input  logic [WORD_W-1:0]   vel_z,
  input  logic [RUNG_W-1:0]   rung,
  // result side
  output logic                empty,
  input  logic                pop,
  output logic [PTR_W-1:0]    split_point,
  output logic [WORD_W-1:0]   out_pos_x,
  output logic [WORD_W-1:0]   out_pos_y,
  output logic [WORD_W-1:0]   out_pos_z,
  output logic [WORD_W-1:0]   out_vel_x,
  output logic [WORD_W-1:0]   out_vel_y,
  output logic [WORD_W-1:0]   out_vel_z,
  output logic [RUNG_W-1:0]   out_rung
);

  record_t in_rec;
  record_t out_rec;
  cmd_t    front_cmd;
  cmd_t    back_cmd;
  logic    cmd_empty;
  logic    cmd_pop;

  // gather the incoming record fields
  assign in_rec.pos_x = pos_x;
  assign in_rec.pos_y = pos_y;
  assign in_rec.pos_z = pos_z;
  assign in_rec.vel_x = vel_x;
  assign in_rec.vel_y = vel_y;
  assign in_rec.vel_z = vel_z;
  assign in_rec.rung = rung;

  // front: classify each command before it is queued
  ppe_front #(
    .CAPACITY(CAPACITY)
  ) u_front (
    .command  (command),
    .index    (index),
    .range_end(range_end),
    .split_dim(split_dim),
    .pivot    (pivot),
    .rec      (in_rec),
    .cmd      (front_cmd)
  );

  // queue decouples command transfers from the engine
  ppe_cmd_fifo u_fifo (
    .clk   (clk),
    .rst   (rst),
    .wr_en (push),
    .wr_cmd(front_cmd),
    .full  (full),
    .rd_en (cmd_pop),
    .rd_cmd(back_cmd),
    .empty (cmd_empty)
  );

  // back: memory plus sequencer, result held until its transfer
  ppe_back #(
    .CAPACITY(CAPACITY)
  ) u_back (
    .clk        (clk),
    .rst        (rst),
    .cmd        (back_cmd),
    .cmd_empty  (cmd_empty),
    .cmd_pop    (cmd_pop),
    .pop        (pop),
    .empty      (empty),
    .split_point(split_point),
    .out_rec    (out_rec)
  );

  // spread the result record onto its ports
  assign out_pos_x = out_rec.pos_x;
  assign out_pos_y = out_rec.pos_y;
  assign out_pos_z = out_rec.pos_z;
  assign out_vel_x = out_rec.vel_x;
  assign out_vel_y = out_rec.vel_y;
  assign out_vel_z = out_rec.vel_z;
  assign out_rung = out_rec.rung;

endmodule

// ----- tb/testbench.sv -----
// ----------------------------------------------------------------------------
// testbench
// self-checking bench for the particle partition engine
// ----------------------------------------------------------------------------
// A directed table covers extremes, every command and the corner cases. It is
// followed by random writes, reads and partitions. Every accepted command is
// fed to a local copy of the record store, which predicts the result. The
// result side pops with random stalls and compares each transfer against the
// oldest expected result, field by field.
module testbench;
  import ppe_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int SLOTS = CAPACITY_DEF;
  localparam int RANDOM_ITEMS = 1600;
  localparam longint CYCLE_LIMIT = 3000000;

  // codes outside the defined sets
  localparam logic [1:0] CMD_UNUSED = 2'd3;
  localparam logic [1:0] DIM_UNUSED = 2'd3;

  typedef struct {
    logic [1:0]        cmd;
    logic [IDX_W-1:0]  idx;
    logic [PTR_W-1:0]  rend;
    logic [1:0]        dim;
    logic [WORD_W-1:0] pv;
    record_t           rec;
  } command_t;

  typedef struct {
    logic [PTR_W-1:0] split;
    record_t          rec;
  } outcome_t;

  typedef struct {
    command_t  c;
    bit        typed;
    outcome_t  want;
  } table_row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic push = 1'b0;
  logic full;
  logic [1:0] command = '0;
  logic [IDX_W-1:0] index = '0;
  logic [PTR_W-1:0] range_end = '0;
  logic [1:0] split_dim = '0;
  logic [WORD_W-1:0] pivot = '0;
  logic [WORD_W-1:0] pos_x = '0, pos_y = '0, pos_z = '0;
  logic [WORD_W-1:0] vel_x = '0, vel_y = '0, vel_z = '0;
  logic [RUNG_W-1:0] rung = '0;
  logic empty;
  logic pop = 1'b0;
  logic [PTR_W-1:0] split_point;
  logic [WORD_W-1:0] out_pos_x, out_pos_y, out_pos_z;
  logic [WORD_W-1:0] out_vel_x, out_vel_y, out_vel_z;
  logic [RUNG_W-1:0] out_rung;

  // local copy of the record store and which slots have been written
  record_t store_copy [SLOTS];
  bit      slot_valid [SLOTS];
  int      valid_slots[$];

  outcome_t pending_results[$];
  int       mismatches = 0;
  longint   cycle_count = 0;
  int       hold_request = 0;   // long receiver stall asked by the sender
  bit       no_gaps = 1'b0;     // stretch with no receiver stalls

  always #5 clk = ~clk;

  particle_partition_engine_top u_top (
    .clk(clk), .rst(rst),
    .push(push), .full(full), .command(command), .index(index),
    .range_end(range_end), .split_dim(split_dim), .pivot(pivot),
    .pos_x(pos_x), .pos_y(pos_y), .pos_z(pos_z),
    .vel_x(vel_x), .vel_y(vel_y), .vel_z(vel_z), .rung(rung),
    .empty(empty), .pop(pop), .split_point(split_point),
    .out_pos_x(out_pos_x), .out_pos_y(out_pos_y), .out_pos_z(out_pos_z),
    .out_vel_x(out_vel_x), .out_vel_y(out_vel_y), .out_vel_z(out_vel_z),
    .out_rung(out_rung)
  );

  task automatic report(input string what, input logic [63:0] got, input logic [63:0] want);
    $display("mismatch at %0t: %s got %0h expected %0h", $realtime, what, got, want);
    mismatches++;
  endtask

  function automatic logic [WORD_W-1:0] sort_key(input int slot, input logic [1:0] dim);
    case (dim)
      DIM_X:   return store_copy[slot].pos_x;
      DIM_Y:   return store_copy[slot].pos_y;
      default: return store_copy[slot].pos_z;   // unused code acts as z
    endcase
  endfunction

  // two-ended scan: low pointer looks for a key at or above pivot, high
  // pointer walks down for one below it, then the whole records swap
  function automatic int partition_copy(input int first, input int last,
                                        input logic [1:0] dim, input logic [WORD_W-1:0] pv);
    int lo;
    int hi;
    record_t t;
    lo = first;
    hi = last;
    while (lo < hi) begin
      if (sort_key(lo, dim) >= pv) begin
        while (lo != hi) begin
          hi--;
          if (sort_key(hi, dim) < pv) begin
            t = store_copy[lo];
            store_copy[lo] = store_copy[hi];
            store_copy[hi] = t;
            break;
          end
        end
      end
      lo++;
    end
    return hi;
  endfunction

  function automatic outcome_t predict_outcome(input command_t c);
    outcome_t o;
    int last;
    o.split = '0;
    o.rec = '0;
    case (c.cmd)
      CMD_WRITE: begin
        store_copy[c.idx] = c.rec;
        if (!slot_valid[c.idx]) begin
          slot_valid[c.idx] = 1'b1;
          valid_slots.insert(valid_slots.size(), int'(c.idx));
        end
      end
      CMD_PART: begin
        last = (int'(c.rend) > SLOTS) ? SLOTS : int'(c.rend);
        if (int'(c.idx) >= last) o.split = last[PTR_W-1:0];
        else o.split = PTR_W'(partition_copy(int'(c.idx), last, c.dim, c.pv));
      end
      CMD_READ: o.rec = store_copy[c.idx];
      default: ;
    endcase
    return o;
  endfunction

  function automatic record_t random_record();
    record_t r;
    r.pos_x = $urandom;
    r.pos_y = $urandom;
    r.pos_z = $urandom;
    // a few small keys give ties and equal-to-pivot cases
    if ($urandom_range(0, 3) == 0) begin
      r.pos_x = $urandom_range(0, 4);
      r.pos_y = $urandom_range(0, 4);
      r.pos_z = $urandom_range(0, 4);
    end
    r.vel_x = $urandom;
    r.vel_y = $urandom;
    r.vel_z = $urandom;
    r.rung = RUNG_W'($urandom);
    return r;
  endfunction

  // offer one command, wait for the transfer, then idle for the given gap
  task automatic send(input command_t c, input bit typed, input outcome_t want, input int gap);
    outcome_t o;
    push <= 1'b1;
    command <= c.cmd;
    index <= c.idx;
    range_end <= c.rend;
    split_dim <= c.dim;
    pivot <= c.pv;
    pos_x <= c.rec.pos_x;
    pos_y <= c.rec.pos_y;
    pos_z <= c.rec.pos_z;
    vel_x <= c.rec.vel_x;
    vel_y <= c.rec.vel_y;
    vel_z <= c.rec.vel_z;
    rung <= c.rec.rung;
    do @(posedge clk); while (full);
    o = predict_outcome(c);
    pending_results.insert(pending_results.size(), typed ? want : o);
    if (gap > 0) begin
      push <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  function automatic int random_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 65) return 0;
    if (r < 95) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  function automatic command_t random_command();
    command_t c;
    int r;
    int s;
    int e;
    int len;
    r = $urandom_range(0, 99);
    c.cmd = CMD_WRITE;
    c.idx = IDX_W'($urandom);
    c.rend = PTR_W'($urandom);
    c.dim = 2'($urandom);
    c.pv = $urandom;
    c.rec = random_record();
    if (r < 35) begin
      // writes mostly land in a small window so ranges of valid slots grow
      if ($urandom_range(0, 3) != 0) c.idx = IDX_W'($urandom_range(0, 127));
    end else if (r < 62) begin
      c.cmd = CMD_READ;
      c.idx = IDX_W'(valid_slots[$urandom_range(0, valid_slots.size() - 1)]);
    end else if (r < 95) begin
      c.cmd = CMD_PART;
      s = valid_slots[$urandom_range(0, valid_slots.size() - 1)];
      len = ($urandom_range(0, 99) == 0) ? SLOTS : $urandom_range(1, 40);
      e = s;
      while (e < SLOTS && slot_valid[e] && e - s < len) e++;
      c.idx = IDX_W'(s);
      c.rend = (e == SLOTS && $urandom_range(0, 1)) ? PTR_W'($urandom_range(SLOTS, 2047))
                                                     : PTR_W'(e);
      case ($urandom_range(0, 3))
        0: c.pv = sort_key($urandom_range(s, e - 1), c.dim);
        1: c.pv = ($urandom_range(0, 1)) ? '0 : '1;
        default: c.pv = $urandom;
      endcase
    end else begin
      // unused command, or a partition over an empty or inverted range
      if ($urandom_range(0, 1)) begin
        c.cmd = CMD_UNUSED;
      end else begin
        c.cmd = CMD_PART;
        c.rend = PTR_W'($urandom_range(0, c.idx));
      end
    end
    return c;
  endfunction

  function automatic table_row_t row(input logic [1:0] cmd, input int idx, input int rend,
                                     input logic [1:0] dim, input logic [WORD_W-1:0] pv,
                                     input record_t rec, input bit typed,
                                     input int split, input record_t want_rec);
    table_row_t t;
    t.c.cmd = cmd;
    t.c.idx = IDX_W'(idx);
    t.c.rend = PTR_W'(rend);
    t.c.dim = dim;
    t.c.pv = pv;
    t.c.rec = rec;
    t.typed = typed;
    t.want.split = PTR_W'(split);
    t.want.rec = want_rec;
    return t;
  endfunction

  // result side: random stalls, one long hold on request, checking each transfer
  int stall_left = 0;
  always @(posedge clk) begin
    outcome_t w;
    if (!rst && pop && !empty) begin
      if (pending_results.size() == 0) begin
        report("unexpected result", 64'(split_point), 64'(0));
      end else begin
        w = pending_results.pop_front();
        if (split_point !== w.split)
          report("split_point", 64'(split_point), 64'(w.split));
        if (out_pos_x !== w.rec.pos_x)
          report("out_pos_x", 64'(out_pos_x), 64'(w.rec.pos_x));
        if (out_pos_y !== w.rec.pos_y)
          report("out_pos_y", 64'(out_pos_y), 64'(w.rec.pos_y));
        if (out_pos_z !== w.rec.pos_z)
          report("out_pos_z", 64'(out_pos_z), 64'(w.rec.pos_z));
        if (out_vel_x !== w.rec.vel_x)
          report("out_vel_x", 64'(out_vel_x), 64'(w.rec.vel_x));
        if (out_vel_y !== w.rec.vel_y)
          report("out_vel_y", 64'(out_vel_y), 64'(w.rec.vel_y));
        if (out_vel_z !== w.rec.vel_z)
          report("out_vel_z", 64'(out_vel_z), 64'(w.rec.vel_z));
        if (out_rung !== w.rec.rung)
          report("out_rung", 64'(out_rung), 64'(w.rec.rung));
      end
    end
    if (hold_request > 0) begin
      stall_left = hold_request;
      hold_request = 0;
    end
    if (rst) begin
      pop <= 1'b0;
    end else if (stall_left > 0) begin
      pop <= 1'b0;
      stall_left--;
    end else begin
      pop <= 1'b1;
      if (!no_gaps) begin
        case ($urandom_range(0, 49))
          0, 1, 2, 3, 4, 5, 6, 7: stall_left = $urandom_range(1, 3);
          8: stall_left = $urandom_range(10, 60);
          default: ;
        endcase
      end
    end
  end

  // run limit
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("testbench: FAIL");
      $finish;
    end
  end

  initial begin
    table_row_t dir[$];
    record_t ones;
    record_t zero;
    record_t pat;
    record_t low;
    outcome_t none;
    command_t c;
    int settle;

    ones = '1;
    zero = '0;
    none.split = '0;
    none.rec = '0;
    pat = {32'hA5A5_5A5A, 32'h8000_0000, 32'h0000_0001, 32'hDEAD_BEEF,
           32'h1234_5678, 32'h0F0F_F0F0, 8'h5A};
    low = {32'd5, 32'd5, 32'd5, 32'd7, 32'd8, 32'd9, 8'h3C};

    // extremes, every command and the corner cases
    dir.insert(dir.size(), row(CMD_WRITE, 0, 0, DIM_X, 0, ones, 1, 0, zero));
    dir.insert(dir.size(), row(CMD_READ, 0, 0, DIM_X, 0, zero, 1, 0, ones));
    dir.insert(dir.size(), row(CMD_WRITE, 1, 0, DIM_X, 0, zero, 1, 0, zero));
    dir.insert(dir.size(), row(CMD_READ, 1, 0, DIM_X, 0, zero, 1, 0, zero));
    dir.insert(dir.size(), row(CMD_WRITE, 2, 0, DIM_X, 0, low, 1, 0, zero));
    dir.insert(dir.size(), row(CMD_WRITE, 1023, 0, DIM_X, 0, pat, 1, 0, zero));
    dir.insert(dir.size(), row(CMD_READ, 1023, 0, DIM_X, 0, zero, 1, 0, pat));
    // empty and inverted ranges return range_end untouched
    dir.insert(dir.size(), row(CMD_PART, 5, 5, DIM_X, 0, zero, 1, 5, zero));
    dir.insert(dir.size(), row(CMD_PART, 9, 3, DIM_Y, 0, zero, 1, 3, zero));
    dir.insert(dir.size(), row(CMD_PART, 1023, 0, DIM_Z, 0, zero, 1, 0, zero));
    // partitions of slots 0..2 on each dimension; with pivot zero every key is at or above it
    dir.insert(dir.size(), row(CMD_PART, 0, 3, DIM_X, 0, zero, 1, 0, zero));
    dir.insert(dir.size(), row(CMD_PART, 0, 3, DIM_Y, '1, zero, 0, 0, zero));
    dir.insert(dir.size(), row(CMD_PART, 0, 3, DIM_Z, 6, zero, 0, 0, zero));
    // unused dimension code sorts on z
    dir.insert(dir.size(), row(CMD_PART, 0, 3, DIM_UNUSED, 1, zero, 0, 0, zero));
    // end above capacity saturates
    dir.insert(dir.size(), row(CMD_PART, 1023, 2047, DIM_X, 32'h8000_0000, zero, 0, 0, zero));
    dir.insert(dir.size(), row(CMD_PART, 1023, 1024, DIM_Y, 0, zero, 1, 1023, zero));
    // unused command code changes nothing
    dir.insert(dir.size(), row(CMD_UNUSED, 1023, 2047, DIM_UNUSED, '1, ones, 1, 0, zero));
    dir.insert(dir.size(), row(CMD_READ, 0, 0, DIM_X, 0, zero, 0, 0, zero));
    dir.insert(dir.size(), row(CMD_READ, 1, 0, DIM_X, 0, zero, 0, 0, zero));
    dir.insert(dir.size(), row(CMD_READ, 2, 0, DIM_X, 0, zero, 0, 0, zero));
    dir.insert(dir.size(), row(CMD_READ, 1023, 0, DIM_X, 0, zero, 0, 0, zero));

    repeat (6) @(posedge clk);
    rst <= 1'b0;

    foreach (dir[i]) send(dir[i].c, dir[i].typed, dir[i].want, random_gap());

    // sender pauses until every result is back
    push <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);

    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      if (n == 400) hold_request = 400;   // receiver holds while the queue fills
      if (n == 900) no_gaps = 1'b1;
      if (n == 1100) no_gaps = 1'b0;
      if (n == 1200) begin
        push <= 1'b0;
        while (pending_results.size() != 0) @(posedge clk);
      end
      c = random_command();
      send(c, 1'b0, none, (n >= 400 && n < 450) || (n >= 900 && n < 1100) ? 0 : random_gap());
    end
    push <= 1'b0;

    while (pending_results.size() != 0) @(posedge clk);
    settle = 0;
    while (settle < 100) begin
      @(posedge clk);
      settle++;
    end

    if (mismatches == 0) begin
      $display("testbench: PASS");
    end else begin
      $display("testbench: FAIL");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
src/ppe_pkg.sv
src/ppe_front.sv
src/ppe_cmd_fifo.sv
src/ppe_back.sv
src/particle_partition_engine_top.sv
tb/testbench.sv
